[src/rtnp_pkg.sv]
// Shared types, constants and helpers for the ringtone note token parser.
// No dependencies; every other file in src but rtnp_stream_if refers to this package by scoped name.
package rtnp_pkg;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_DURATION = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_OCTAVE   = 1'd1;

    localparam logic [7:0] RST_DEFAULT_DURATION = 8'd4;
    localparam logic [4:0] RST_DEFAULT_OCTAVE   = 5'd6;

    // Limits and codes
    localparam logic [7:0] MAX_DURATION     = 8'd128;
    localparam logic [7:0] MAX_OCTAVE       = 8'd16;
    localparam logic [4:0] MAX_DOTS         = 5'd16;
    localparam logic [4:0] DOTS_SAT         = 5'd31;
    localparam logic [7:0] ACC_SAT          = 8'd255;
    localparam logic [7:0] PAUSE_CODE       = 8'hFF;

    // Characters
    localparam logic [7:0] CH_SHARP_A = 8'h23;  // '#'
    localparam logic [7:0] CH_SHARP_B = 8'h5F;  // '_'
    localparam logic [7:0] CH_DOT     = 8'h2E;  // '.'
    localparam logic [7:0] CH_COMMA   = 8'h2C;  // ','
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_G = 8'h47;
    localparam logic [7:0] CH_UPPER_P = 8'h50;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CASE_OFFSET = 8'd32;

    // Letter codes: 1..7 are A..G
    localparam logic [3:0] LETTER_NONE  = 4'd0;
    localparam logic [3:0] LETTER_A     = 4'd1;
    localparam logic [3:0] LETTER_P     = 4'd8;
    localparam logic [3:0] LETTER_OTHER = 4'd9;

    typedef struct packed {
        logic       digit_hit;
        logic [3:0] digit;
        logic [3:0] letter;
        logic       is_sharp;
        logic       is_dot;
        logic       is_blank;
        logic       is_comma;
    } char_class_t;

    typedef struct packed {
        logic [7:0] duration;
        logic [3:0] letter;
        logic       sharp;
        logic [7:0] octave;
        logic [4:0] dots;
    } token_t;

    typedef struct packed {
        logic [7:0] semitone;
        logic [7:0] note_length;
        logic [4:0] dot_count;
        logic       is_error;
    } result_t;

    // Semitone offset of a letter within its octave (index is letter code mod 8)
    function automatic logic [3:0] pitch_of(input logic [2:0] idx);
        logic [3:0] p;
        case (idx)
            3'd1:    p = 4'd9;
            3'd2:    p = 4'd11;
            3'd3:    p = 4'd0;
            3'd4:    p = 4'd2;
            3'd5:    p = 4'd4;
            3'd6:    p = 4'd5;
            3'd7:    p = 4'd7;
            default: p = 4'd0;
        endcase
        return p;
    endfunction

    // acc*10 + digit, saturating at 255
    function automatic logic [7:0] add_digit(input logic [7:0] acc, input logic [3:0] d);
        logic [11:0] v;
        v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {8'd0, d};
        return (v > {4'd0, ACC_SAT}) ? ACC_SAT : v[7:0];
    endfunction

endpackage

[src/rtnp_stream_if.sv]
// Valid/ready stream interfaces for the character input and the note output.
// Uses no package; the note payload is carried as separate logic fields.
interface rtnp_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       end_of_text;

    modport source (output valid, output char_code, output end_of_text, input ready);
    modport sink   (input valid, input char_code, input end_of_text, output ready);
endinterface

interface rtnp_note_if;
    logic       valid;
    logic       ready;
    logic [7:0] semitone;
    logic [7:0] note_length;
    logic [4:0] dot_count;
    logic       is_error;

    modport source (output valid, output semitone, output note_length,
                    output dot_count, output is_error, input ready);
    modport sink   (input valid, input semitone, input note_length,
                    input dot_count, input is_error, output ready);
endinterface

[src/rtnp_char_class.sv]
// Character classifier: decodes one text byte into digit, letter and mark flags.
// Depends on rtnp_pkg.
module rtnp_char_class (
    input  logic [7:0]           char_code,
    output rtnp_pkg::char_class_t cls
);

    logic [7:0] upper;
    logic [7:0] digit_full;
    logic [7:0] letter_full;

    // Fold lower case onto upper case
    always_comb
    begin
        if (char_code >= rtnp_pkg::CH_LOWER_A && char_code <= rtnp_pkg::CH_LOWER_Z)
            upper = char_code - rtnp_pkg::CASE_OFFSET;
        else
            upper = char_code;
        digit_full  = char_code - rtnp_pkg::CH_ZERO;
        letter_full = upper - rtnp_pkg::CH_UPPER_A + {4'd0, rtnp_pkg::LETTER_A};
    end

    // Build the class flags
    always_comb
    begin
        cls.digit_hit = (char_code >= rtnp_pkg::CH_ZERO) && (char_code <= rtnp_pkg::CH_NINE);
        cls.digit     = digit_full[3:0];
        if (upper >= rtnp_pkg::CH_UPPER_A && upper <= rtnp_pkg::CH_UPPER_G)
            cls.letter = letter_full[3:0];
        else if (upper == rtnp_pkg::CH_UPPER_P)
            cls.letter = rtnp_pkg::LETTER_P;
        else if (upper >= rtnp_pkg::CH_UPPER_A && upper <= rtnp_pkg::CH_UPPER_Z)
            cls.letter = rtnp_pkg::LETTER_OTHER;
        else
            cls.letter = rtnp_pkg::LETTER_NONE;
        cls.is_sharp = (char_code == rtnp_pkg::CH_SHARP_A) || (char_code == rtnp_pkg::CH_SHARP_B);
        cls.is_dot   = (char_code == rtnp_pkg::CH_DOT);
        cls.is_blank = (char_code == rtnp_pkg::CH_SPACE) || (char_code == rtnp_pkg::CH_TAB);
        cls.is_comma = (char_code == rtnp_pkg::CH_COMMA);
    end

endmodule

[src/rtnp_note_calc.sv]
// Token closer: applies defaults, validates a token and forms the note result.
// Depends on rtnp_pkg.
module rtnp_note_calc (
    input  rtnp_pkg::token_t  tok,
    input  logic [7:0]        default_duration,
    input  logic [4:0]        default_octave,
    output rtnp_pkg::result_t result,
    output logic              invalid
);

    logic [7:0] dur;
    logic [7:0] oct;
    logic       ok;
    logic [7:0] semi;
    logic [7:0] base;

    // Substitute defaults and check ranges
    always_comb
    begin
        dur = (tok.duration != 8'd0) ? tok.duration : default_duration;
        oct = (tok.octave != 8'd0) ? tok.octave : {3'd0, default_octave};
        ok  = (dur != 8'd0) && (dur <= rtnp_pkg::MAX_DURATION)
              && (tok.letter != rtnp_pkg::LETTER_NONE) && (tok.letter <= rtnp_pkg::LETTER_P)
              && (oct <= rtnp_pkg::MAX_OCTAVE) && (tok.dots <= rtnp_pkg::MAX_DOTS);
        invalid = !ok;
    end

    // Octave times twelve as shift-add, then pitch and sharp; a pause takes the pause code
    always_comb
    begin
        base = {oct[4:0], 3'b000} + {1'b0, oct[4:0], 2'b00};
        if (tok.letter == rtnp_pkg::LETTER_P)
            semi = rtnp_pkg::PAUSE_CODE;
        else
            semi = base + {4'd0, rtnp_pkg::pitch_of(tok.letter[2:0])} + {7'd0, tok.sharp};
    end

    // On error zero all other fields and set is_error
    always_comb
    begin
        if (ok)
        begin
            result.semitone    = semi;
            result.note_length = dur;
            result.dot_count   = tok.dots;
            result.is_error    = 1'b0;
        end
        else
        begin
            result.semitone    = 8'd0;
            result.note_length = 8'd0;
            result.dot_count   = 5'd0;
            result.is_error    = 1'b1;
        end
    end

endmodule

[src/rtnp_token_core.sv]
// Token parser state machine: field accumulators, phase and error latch.
// Depends on rtnp_pkg and rtnp_note_calc.
module rtnp_token_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step_en,
    input  rtnp_pkg::char_class_t cls,
    input  logic                  last,
    input  logic [7:0]            default_duration,
    input  logic [4:0]            default_octave,
    output logic                  emit,
    output rtnp_pkg::result_t     result
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_DUR,
        PH_SHARP,
        PH_OCT,
        PH_DOTS,
        PH_SKIP
    } phase_t;

    phase_t           phase_reg;
    phase_t           phase_work;
    phase_t           phase_step;
    phase_t           phase_next;
    rtnp_pkg::token_t tok_reg;
    rtnp_pkg::token_t tok_work;
    rtnp_pkg::token_t tok_step;
    rtnp_pkg::token_t tok_next;
    logic             err_reg;
    logic             err_next;
    logic             close;
    logic             invalid;

    // Advance the token by one character
    always_comb
    begin
        phase_work = phase_reg;
        tok_work   = tok_reg;
        if (phase_reg == PH_IDLE && !cls.is_blank)
        begin
            phase_work = PH_DUR;
            tok_work   = '0;
        end
        phase_step = phase_work;
        tok_step   = tok_work;
        if (!(phase_work != PH_IDLE && cls.is_comma))
        begin
            unique case (phase_work)
                PH_DUR:
                begin
                    if (cls.digit_hit)
                        tok_step.duration = rtnp_pkg::add_digit(tok_work.duration, cls.digit);
                    else
                    begin
                        tok_step.letter = cls.letter;
                        phase_step = (cls.letter != rtnp_pkg::LETTER_NONE) ? PH_SHARP : PH_SKIP;
                    end
                end
                PH_SHARP:
                begin
                    if (cls.is_sharp)
                    begin
                        tok_step.sharp = 1'b1;
                        phase_step     = PH_OCT;
                    end
                    else if (cls.digit_hit)
                    begin
                        tok_step.octave = rtnp_pkg::add_digit(tok_work.octave, cls.digit);
                        phase_step      = PH_OCT;
                    end
                    else if (cls.is_dot)
                    begin
                        tok_step.dots = 5'd1;
                        phase_step    = PH_DOTS;
                    end
                    else
                        phase_step = PH_SKIP;
                end
                PH_OCT:
                begin
                    if (cls.digit_hit)
                        tok_step.octave = rtnp_pkg::add_digit(tok_work.octave, cls.digit);
                    else if (cls.is_dot)
                    begin
                        tok_step.dots = 5'd1;
                        phase_step    = PH_DOTS;
                    end
                    else
                        phase_step = PH_SKIP;
                end
                PH_DOTS:
                begin
                    if (cls.is_dot)
                    begin
                        if (tok_work.dots < rtnp_pkg::DOTS_SAT)
                            tok_step.dots = tok_work.dots + 5'd1;
                    end
                    else
                        phase_step = PH_SKIP;
                end
                PH_IDLE, PH_SKIP:
                begin
                end
                default:
                begin
                end
            endcase
        end
        close = !err_reg && (phase_step != PH_IDLE) && (cls.is_comma || last);
    end

    rtnp_note_calc u_note_calc (
        .tok              (tok_step),
        .default_duration (default_duration),
        .default_octave   (default_octave),
        .result           (result),
        .invalid          (invalid)
    );

    // Choose next state: hold on error, clear on close or end of text
    always_comb
    begin
        phase_next = phase_reg;
        tok_next   = tok_reg;
        err_next   = err_reg;
        if (!err_reg)
        begin
            if (close)
            begin
                phase_next = PH_IDLE;
                tok_next   = '0;
                err_next   = invalid;
            end
            else
            begin
                phase_next = phase_step;
                tok_next   = tok_step;
            end
        end
        if (last)
        begin
            phase_next = PH_IDLE;
            tok_next   = '0;
            err_next   = 1'b0;
        end
        emit = close;
    end

    // Hold parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            tok_reg   <= '0;
            err_reg   <= 1'b0;
        end
        else if (step_en)
        begin
            phase_reg <= phase_next;
            tok_reg   <= tok_next;
            err_reg   <= err_next;
        end
    end

endmodule

[src/ringtone_note_token_parser.sv]
// Top level of the ringtone note token parser: input register, config registers,
// token core and output register. Depends on rtnp_pkg, rtnp_stream_if,
// rtnp_char_class and rtnp_token_core.
//
//   port       | dir  | transaction carries
//   -----------+------+--------------------------------------------------------
//   char_in    | sink | char_code, end_of_text (one text byte)
//   note_out   | src  | semitone, note_length, dot_count, is_error (per token)
//   cfg_*      | in   | write of default_duration (0) or default_octave (1)
//
// One character per cycle sustained while results can drain. A character passes
// an input register, is parsed against the token state, and a closing character
// loads the output register when the parse step is taken. The input register and
// the output register decouple the two sides: a character is taken while a
// result waits, and only a result that cannot be loaded holds the parse step.
// Reset clears the valid flags and parser state; defaults return to 4 and 6.
module ringtone_note_token_parser (
    input  logic                          clk,
    input  logic                          rst_n,
    rtnp_char_if.sink                     char_in,
    rtnp_note_if.source                   note_out,
    input  logic                          cfg_we,
    input  logic [rtnp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                    cfg_wdata
);

    logic                  in_valid_reg;
    logic [7:0]            char_reg;
    logic                  last_reg;
    logic                  out_valid_reg;
    rtnp_pkg::result_t     result_reg;
    logic [7:0]            default_duration_reg;
    logic [4:0]            default_octave_reg;
    logic                  step_en;
    logic                  emit;
    rtnp_pkg::result_t     result;
    rtnp_pkg::char_class_t cls;

    // Step when a character is held and its result, if any, has room
    assign step_en       = in_valid_reg && (!emit || !out_valid_reg || note_out.ready);
    assign char_in.ready = !in_valid_reg || step_en;

    // Hold the incoming character
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (char_in.ready)
            in_valid_reg <= char_in.valid;
    end

    always_ff @(posedge clk)
    begin
        if (char_in.valid && char_in.ready)
        begin
            char_reg <= char_in.char_code;
            last_reg <= char_in.end_of_text;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            default_duration_reg <= rtnp_pkg::RST_DEFAULT_DURATION;
            default_octave_reg   <= rtnp_pkg::RST_DEFAULT_OCTAVE;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rtnp_pkg::CFG_DEFAULT_DURATION: default_duration_reg <= cfg_wdata;
                rtnp_pkg::CFG_DEFAULT_OCTAVE:   default_octave_reg   <= cfg_wdata[4:0];
                default:
                begin
                end
            endcase
        end
    end

    rtnp_char_class u_char_class (
        .char_code (char_reg),
        .cls       (cls)
    );

    rtnp_token_core u_token_core (
        .clk              (clk),
        .rst_n            (rst_n),
        .step_en          (step_en),
        .cls              (cls),
        .last             (last_reg),
        .default_duration (default_duration_reg),
        .default_octave   (default_octave_reg),
        .emit             (emit),
        .result           (result)
    );

    // Load or drain the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (step_en && emit)
            out_valid_reg <= 1'b1;
        else if (note_out.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (step_en && emit)
            result_reg <= result;
    end

    assign note_out.valid       = out_valid_reg;
    assign note_out.semitone    = result_reg.semitone;
    assign note_out.note_length = result_reg.note_length;
    assign note_out.dot_count   = result_reg.dot_count;
    assign note_out.is_error    = result_reg.is_error;

endmodule
